>>> rtl/core/ack_line_watcher_unit_assert.svh
// assertion macros for the ack line watcher
// no dependencies; expects clk and arst_n in the including scope
`ifndef ACK_LINE_WATCHER_UNIT_ASSERT_SVH
`define ACK_LINE_WATCHER_UNIT_ASSERT_SVH

// same-cycle implication
`define ALW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ALW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/alw_pkg.sv
// shared types and constants for the ack line watcher
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package alw_pkg;

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_BYTE  = 2'd1,
		ACT_TICK  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		VERDICT_NONE    = 2'd0,
		VERDICT_OK      = 2'd1,
		VERDICT_FAIL    = 2'd2,
		VERDICT_TIMEOUT = 2'd3
	} verdict_t;

	// result beat, verdict in the low bits
	typedef struct packed {
		logic     armed;
		verdict_t verdict;
	} alw_result_t;

	// control handed to every match cell
	typedef struct packed {
		logic clear;
		logic flush;
		logic step;
	} alw_cell_ctl_t;

	localparam logic [7:0] CHAR_NUL = 8'h00;
	localparam logic [7:0] CHAR_LF  = 8'h0A;
	localparam logic [7:0] CHAR_CR  = 8'h0D;

	// patterns, first character in the lowest byte
	localparam int unsigned OK_LEN   = 3;
	localparam int unsigned FAIL_LEN = 5;
	localparam logic [8*OK_LEN-1:0]   OK_TEXT   = 24'h4B_4F_24;
	localparam logic [8*FAIL_LEN-1:0] FAIL_TEXT = 40'h4C_49_41_46_24;

	localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

endpackage

`default_nettype wire

>>> rtl/core/ack_line_watcher_unit.sv
// ack line watcher: watches received bytes for an "$OK" or "$FAIL" line
// slave beat: tuser = action (start, byte, tick), tdata = received byte.
// master beat: tdata = verdict (none, ok, fail, timeout) and armed flag.
// a start arms the watcher and clears the line and the elapsed ms count;
// a timeout of zero answers timeout at once. cr is skipped, lf ends the line.
// one result beat per input beat, registered in the output buffer and shown
// on the master side from there. one input beat per cycle while s_tready is
// high; the match cell rows and the length and ms counters update on the beat.
// a two-entry output buffer holds results while the receiver stalls; s_tready
// drops only when both entries are full and rises once one is taken.
// config: cfg_data writes timeout_ms, always ready; write only while idle.
// reset: watcher idle, line cleared, timeout_ms 2000, output buffer empty.
// depends on alw_pkg, alw_match_chain and the assertion header
`timescale 1ns / 1ps
`default_nettype none

`include "ack_line_watcher_unit_assert.svh"

module ack_line_watcher_unit
	import alw_pkg::*;
#(
	parameter int unsigned LINE_MAX = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  wire logic [1:0]  s_tuser,   // [1:0] action
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [1:0] verdict, [2] armed, [7:3] zero
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);

	localparam int unsigned LEN_W = $clog2(LINE_MAX + 1);

	logic [15:0]      timeout_q;
	logic             waiting_q;
	logic [LEN_W-1:0] len_q;
	logic             early_q;
	logic [15:0]      elapsed_q;

	logic             wait_d;
	logic [LEN_W-1:0] len_d;
	logic             early_d;
	logic [15:0]      elapsed_d;
	logic [15:0]      elapsed_inc;
	verdict_t         verdict_d;
	alw_cell_ctl_t    ctl_d;
	alw_cell_ctl_t    cell_ctl;
	action_t          action;
	logic             saw_ok;
	logic             saw_fail;

	logic             push;
	logic             pop;
	alw_result_t      buf_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;

	assign cfg_ready = 1'b1;
	assign action    = action_t'(s_tuser);
	assign push      = s_tvalid && s_tready;
	assign pop       = m_tvalid && m_tready;
	assign s_tready  = (cnt_q != 2'd2);
	assign m_tvalid  = (cnt_q != 2'd0);
	assign m_tdata   = {5'b0, buf_q[rd_q]};

	assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;

	always_comb begin
		wait_d    = waiting_q;
		len_d     = len_q;
		early_d   = early_q;
		elapsed_d = elapsed_q;
		verdict_d = VERDICT_NONE;
		ctl_d     = '0;
		unique case (action)
			ACT_START: begin
				ctl_d.clear = 1'b1;
				len_d       = '0;
				early_d     = 1'b0;
				elapsed_d   = '0;
				if (timeout_q == 16'd0) begin
					wait_d    = 1'b0;
					verdict_d = VERDICT_TIMEOUT;
				end else begin
					wait_d = 1'b1;
				end
			end
			ACT_BYTE: begin
				if (waiting_q) begin
					priority if (s_tdata == CHAR_CR) begin
						wait_d = waiting_q;
					end else if (s_tdata == CHAR_LF) begin
						priority if (saw_ok) begin
							verdict_d = VERDICT_OK;
							wait_d    = 1'b0;
						end else if (saw_fail) begin
							verdict_d = VERDICT_FAIL;
							wait_d    = 1'b0;
						end else begin
							ctl_d.clear = 1'b1;
							len_d       = '0;
							early_d     = 1'b0;
						end
					end else if (len_q >= LEN_W'(LINE_MAX)) begin
						// full line: drop the byte and start over
						ctl_d.clear = 1'b1;
						len_d       = '0;
						early_d     = 1'b0;
					end else begin
						len_d = len_q + LEN_W'(1);
						if (!early_q) begin
							if (s_tdata == CHAR_NUL) begin
								early_d     = 1'b1;
								ctl_d.flush = 1'b1;
							end else begin
								ctl_d.step = 1'b1;
							end
						end
					end
				end
			end
			ACT_TICK: begin
				if (waiting_q) begin
					elapsed_d = elapsed_inc;
					if (elapsed_inc >= timeout_q) begin
						verdict_d = VERDICT_TIMEOUT;
						wait_d    = 1'b0;
					end
				end
			end
			default: begin
				wait_d = waiting_q;
			end
		endcase
	end

	assign cell_ctl = push ? ctl_d : '0;

	alw_match_chain #(
		.LEN  (OK_LEN),
		.TEXT (OK_TEXT)
	) u_ok_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (cell_ctl),
		.rx_byte (s_tdata),
		.saw     (saw_ok)
	);

	alw_match_chain #(
		.LEN  (FAIL_LEN),
		.TEXT (FAIL_TEXT)
	) u_fail_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (cell_ctl),
		.rx_byte (s_tdata),
		.saw     (saw_fail)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid) begin
			timeout_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q <= 1'b0;
			len_q     <= '0;
			early_q   <= 1'b0;
			elapsed_q <= '0;
		end else if (push) begin
			waiting_q <= wait_d;
			len_q     <= len_d;
			early_q   <= early_d;
			elapsed_q <= elapsed_d;
		end
	end

	// two-entry result buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= '{armed: wait_d, verdict: verdict_d};
		end
	end

	`ALW_ASSERT_NEXT(a_start_arms, push && (action == ACT_START), waiting_q == ($past(timeout_q) != 16'd0), "start did not arm per timeout")
	`ALW_ASSERT_NEXT(a_idle_len_hold, push && !waiting_q && (action == ACT_BYTE), $stable(len_q), "idle watcher changed line length")
	`ALW_ASSERT_NOW(a_stall_has_data, !s_tready, m_tvalid && (cnt_q == 2'd2), "input stalled without full buffer")

endmodule

`default_nettype wire

>>> rtl/core/alw_match_cell.sv
// one character cell of a pattern matcher chain
// depends on alw_pkg
`timescale 1ns / 1ps
`default_nettype none

module alw_match_cell
	import alw_pkg::*;
#(
	parameter logic [7:0] CHAR   = 8'h24,
	parameter bit         STICKY = 1'b0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire alw_cell_ctl_t ctl,
	input  wire logic [7:0]    rx_byte,
	input  wire logic          prev_hit,
	output logic               hit
);

	logic hit_q;
	logic match;

	assign match = prev_hit && (rx_byte == CHAR);
	assign hit   = hit_q;

	// the last cell of a chain keeps its hit until the line is cleared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.clear) begin
			hit_q <= 1'b0;
		end else if (ctl.flush) begin
			hit_q <= STICKY ? hit_q : 1'b0;
		end else if (ctl.step) begin
			hit_q <= STICKY ? (hit_q | match) : match;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/alw_match_chain.sv
// row of match cells that finds one pattern in the byte stream
// depends on alw_pkg and alw_match_cell
`timescale 1ns / 1ps
`default_nettype none

module alw_match_chain
	import alw_pkg::*;
#(
	parameter int unsigned          LEN  = 3,
	parameter logic [8*LEN-1:0]     TEXT = 24'h4B_4F_24
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire alw_cell_ctl_t ctl,
	input  wire logic [7:0]    rx_byte,
	output logic               saw
);

	logic [LEN-1:0] hit;

	// cell i holds "first i+1 characters just seen"; the last one is sticky
	for (genvar i = 0; i < LEN; i++) begin : g_cell
		logic prev;
		if (i == 0) begin : g_head
			assign prev = 1'b1;
		end else begin : g_body
			assign prev = hit[i-1];
		end
		alw_match_cell #(
			.CHAR   (TEXT[8*i +: 8]),
			.STICKY (i == LEN - 1)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.rx_byte  (rx_byte),
			.prev_hit (prev),
			.hit      (hit[i])
		);
	end

	assign saw = hit[LEN-1];

endmodule

`default_nettype wire
